>>> src/arpct_pkg.sv
// Shared types and constants of the ARP cache table.
package arpct_pkg;

    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int TIME_W    = 32;
    localparam int FLAG_W    = 3;
    localparam int CFG_IDX_W = 1;

    // Default table geometry
    localparam int DEF_BUCKETS = 16;
    localparam int DEF_WAYS    = 4;

    // Flag bit positions
    localparam int FLAG_INUSE    = 0;
    localparam int FLAG_COMPLETE = 1;
    localparam int FLAG_HELD     = 2;

    // Item opcodes
    localparam logic OP_RESOLVE = 1'b0;
    localparam logic OP_ARP_RX  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MY_IP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MY_MAC = 1'b1;

    localparam logic [7:0]       OCTET_ZERO  = 8'h00;
    localparam logic [7:0]       OCTET_BCAST = 8'hFF;
    localparam logic [MAC_W-1:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [FLAG_W-1:0] flags;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic              opcode;
        logic [IP_W-1:0]   ip_addr;
        logic [IP_W-1:0]   target_ip;
        logic [MAC_W-1:0]  sender_mac;
        logic              is_request;
        logic              header_ok;
        logic [TIME_W-1:0] now;
    } item_t;

    typedef struct packed {
        logic             resolved;
        logic [MAC_W-1:0] out_mac;
        logic             send_request;
        logic             send_held;
        logic             drop_held;
        logic             send_reply;
    } result_t;

endpackage

>>> src/arpct_mem.sv
// Entry store: one write port, one read port with registered read data.
module arpct_mem #(
    parameter int DEPTH  = arpct_pkg::DEF_BUCKETS * arpct_pkg::DEF_WAYS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output arpct_pkg::entry_t   rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  arpct_pkg::entry_t   wr_data
);

    arpct_pkg::entry_t mem [DEPTH];
    arpct_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/arpct_ctrl.sv
// Sequencer: bucket hash, way scan, decision and write-back, result register.
module arpct_ctrl #(
    parameter int BUCKETS = arpct_pkg::DEF_BUCKETS,
    parameter int WAYS    = arpct_pkg::DEF_WAYS,
    parameter int SLOTS   = BUCKETS * WAYS,
    parameter int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  arpct_pkg::item_t              in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output arpct_pkg::result_t            out_res,
    input  logic [arpct_pkg::IP_W-1:0]    my_ip,
    input  logic [arpct_pkg::MAC_W-1:0]   my_mac,
    output logic                          rd_en,
    output logic [ADDR_W-1:0]             rd_addr,
    input  arpct_pkg::entry_t             rd_data,
    output logic                          wr_en,
    output logic [ADDR_W-1:0]             wr_addr,
    output arpct_pkg::entry_t             wr_data
);

    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCNT_W  = $clog2(WAYS + 1);
    localparam int RW      = $clog2(BUCKETS) + 1;
    localparam int LOG_B   = $clog2(BUCKETS);
    localparam int RECIP_W = arpct_pkg::IP_W + 1;
    localparam int PROD_W  = arpct_pkg::IP_W + RECIP_W;
    localparam bit BKT_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam logic [arpct_pkg::IP_W-1:0] BKT_MASK = BUCKETS - 1;
    // floor(2^(32+LOG_B) / BUCKETS) + 1: exact quotient for any 32-bit address
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << (arpct_pkg::IP_W + LOG_B)) / 64'(BUCKETS) + 64'd1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_REM,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t                         state_reg, state_next;
    logic [ADDR_W-1:0]              clr_cnt_reg, clr_cnt_next;
    logic [WCNT_W-1:0]              issue_reg, issue_next;
    logic                           rvalid_reg, rvalid_next;
    logic                           out_valid_reg, out_valid_next;
    arpct_pkg::result_t             res_reg, res_next;

    arpct_pkg::item_t               item_reg, item_next;
    logic [PROD_W-1:0]              prod_reg, prod_next;
    logic [ADDR_W-1:0]              base_reg, base_next;
    logic [WAY_W-1:0]               rway_reg, rway_next;
    logic                           hit_reg, hit_next;
    logic [WAY_W-1:0]               hit_way_reg, hit_way_next;
    arpct_pkg::entry_t              hit_word_reg, hit_word_next;
    logic                           free_reg, free_next;
    logic [WAY_W-1:0]               pick_way_reg, pick_way_next;
    arpct_pkg::entry_t              pick_word_reg, pick_word_next;
    logic [arpct_pkg::TIME_W-1:0]   oldest_reg, oldest_next;

    logic                           accept;
    logic                           can_load;
    logic                           in_bypass;
    logic [RW-1:0]                  hash_q;
    logic [RW-1:0]                  hash_rem;
    logic [RW-1:0]                  bkt_direct;

    arpct_pkg::result_t             dec_res;
    logic                           dec_wr;
    logic [WAY_W-1:0]               dec_way;
    arpct_pkg::entry_t              dec_word;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign can_load  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // Broadcast resolves and ignored packets skip the table
    always_comb
    begin
        if (in_item.opcode == arpct_pkg::OP_RESOLVE)
        begin
            in_bypass = (in_item.ip_addr[7:0] == arpct_pkg::OCTET_ZERO) ||
                        (in_item.ip_addr[7:0] == arpct_pkg::OCTET_BCAST);
        end
        else
        begin
            in_bypass = !in_item.header_ok || (in_item.sender_mac == my_mac);
        end
    end

    assign bkt_direct = RW'(in_item.ip_addr & BKT_MASK);

    // Remainder by BUCKETS: quotient from the registered reciprocal product,
    // then only the low bits of ip - q * BUCKETS are needed
    assign hash_q   = RW'(prod_reg >> (arpct_pkg::IP_W + LOG_B));
    assign hash_rem = RW'(item_reg.ip_addr) - RW'(hash_q * RW'(BUCKETS));

    // Outcome of one item once its bucket has been scanned
    always_comb
    begin : decide
        logic bcast;
        logic ign;
        logic to_me;
        logic evict_held;

        bcast = (item_reg.ip_addr[7:0] == arpct_pkg::OCTET_ZERO) ||
                (item_reg.ip_addr[7:0] == arpct_pkg::OCTET_BCAST);
        ign   = !item_reg.header_ok || (item_reg.sender_mac == my_mac);
        to_me = (item_reg.target_ip == my_ip);
        evict_held = !free_reg && pick_word_reg.flags[arpct_pkg::FLAG_HELD];

        dec_res  = '0;
        dec_wr   = 1'b0;
        dec_way  = hit_way_reg;
        dec_word = hit_word_reg;

        if (item_reg.opcode == arpct_pkg::OP_RESOLVE)
        begin
            if (bcast)
            begin
                dec_res.resolved = 1'b1;
                dec_res.out_mac  = arpct_pkg::MAC_BCAST;
            end
            else if (hit_reg)
            begin
                dec_wr         = 1'b1;
                dec_word.stamp = item_reg.now;
                if (hit_word_reg.flags[arpct_pkg::FLAG_COMPLETE])
                begin
                    dec_res.resolved = 1'b1;
                    dec_res.out_mac  = hit_word_reg.mac;
                end
                else
                begin
                    dec_res.drop_held    = hit_word_reg.flags[arpct_pkg::FLAG_HELD];
                    dec_word.flags[arpct_pkg::FLAG_HELD] = 1'b1;
                    dec_res.send_request = 1'b1;
                end
            end
            else
            begin
                // miss: new entry, waiting for an answer
                dec_wr         = 1'b1;
                dec_way        = pick_way_reg;
                dec_word       = pick_word_reg;
                dec_word.flags = '0;
                dec_word.flags[arpct_pkg::FLAG_INUSE] = 1'b1;
                dec_word.flags[arpct_pkg::FLAG_HELD]  = 1'b1;
                dec_word.ip    = item_reg.ip_addr;
                dec_word.stamp = '0;
                dec_res.drop_held    = evict_held;
                dec_res.send_request = 1'b1;
            end
        end
        else if (!ign)
        begin
            if (hit_reg)
            begin
                dec_wr       = 1'b1;
                dec_word.mac = item_reg.sender_mac;
                dec_word.flags[arpct_pkg::FLAG_COMPLETE] = 1'b1;
                if (hit_word_reg.flags[arpct_pkg::FLAG_HELD])
                begin
                    dec_word.flags[arpct_pkg::FLAG_HELD] = 1'b0;
                    dec_res.send_held = 1'b1;
                    dec_res.out_mac   = item_reg.sender_mac;
                end
            end
            else if (to_me)
            begin
                dec_wr         = 1'b1;
                dec_way        = pick_way_reg;
                dec_word       = pick_word_reg;
                dec_word.flags = '0;
                dec_word.flags[arpct_pkg::FLAG_INUSE]    = 1'b1;
                dec_word.flags[arpct_pkg::FLAG_COMPLETE] = 1'b1;
                dec_word.ip    = item_reg.ip_addr;
                dec_word.mac   = item_reg.sender_mac;
                dec_word.stamp = '0;
                dec_res.drop_held = evict_held;
            end
            if (to_me && item_reg.is_request)
            begin
                dec_res.send_reply = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        issue_next     = issue_reg;
        rvalid_next    = 1'b0;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        item_next      = item_reg;
        prod_next      = prod_reg;
        base_next      = base_reg;
        rway_next      = rway_reg;
        hit_next       = hit_reg;
        hit_way_next   = hit_way_reg;
        hit_word_next  = hit_word_reg;
        free_next      = free_reg;
        pick_way_next  = pick_way_reg;
        pick_word_next = pick_word_reg;
        oldest_next    = oldest_reg;

        rd_en   = 1'b0;
        rd_addr = base_reg + ADDR_W'(issue_reg);
        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_data = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next   = in_item;
                    hit_next    = 1'b0;
                    issue_next  = '0;
                    base_next   = ADDR_W'(32'(bkt_direct) * WAYS);
                    if (in_bypass)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else if (BKT_POW2)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_HASH;
                    end
                end
            end

            ST_HASH:
            begin
                prod_next  = PROD_W'(item_reg.ip_addr) * PROD_W'(RECIP);
                state_next = ST_REM;
            end

            ST_REM:
            begin
                base_next  = ADDR_W'(32'(hash_rem) * WAYS);
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                // one way read per cycle, data back in the next cycle
                if (issue_reg < WCNT_W'(WAYS))
                begin
                    rd_en       = 1'b1;
                    issue_next  = issue_reg + 1'b1;
                    rvalid_next = 1'b1;
                    rway_next   = WAY_W'(issue_reg);
                end
                if (rvalid_reg)
                begin
                    if (!hit_reg && rd_data.flags[arpct_pkg::FLAG_INUSE] &&
                        (rd_data.ip == item_reg.ip_addr))
                    begin
                        hit_next      = 1'b1;
                        hit_way_next  = rway_reg;
                        hit_word_next = rd_data;
                    end
                    if (rway_reg == '0)
                    begin
                        free_next      = !rd_data.flags[arpct_pkg::FLAG_INUSE];
                        pick_way_next  = rway_reg;
                        pick_word_next = rd_data;
                        oldest_next    = rd_data.stamp;
                    end
                    else if (!free_reg)
                    begin
                        if (!rd_data.flags[arpct_pkg::FLAG_INUSE])
                        begin
                            free_next      = 1'b1;
                            pick_way_next  = rway_reg;
                            pick_word_next = rd_data;
                        end
                        else if (rd_data.stamp < oldest_reg)
                        begin
                            pick_way_next  = rway_reg;
                            pick_word_next = rd_data;
                            oldest_next    = rd_data.stamp;
                        end
                    end
                    if (rway_reg == WAY_W'(WAYS - 1))
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    res_next       = dec_res;
                    wr_en          = dec_wr;
                    wr_addr        = base_reg + ADDR_W'(dec_way);
                    wr_data        = dec_word;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            issue_reg     <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            issue_reg     <= issue_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        prod_reg      <= prod_next;
        base_reg      <= base_next;
        rway_reg      <= rway_next;
        hit_reg       <= hit_next;
        hit_way_reg   <= hit_way_next;
        hit_word_reg  <= hit_word_next;
        free_reg      <= free_next;
        pick_way_reg  <= pick_way_next;
        pick_word_reg <= pick_word_next;
        oldest_reg    <= oldest_next;
    end

endmodule

>>> src/arp_cache_table_unit.sv
// Top level of the set-associative ARP cache table.
//
// Input channel (in_valid / in_stall): one item per resolve request or received
// ARP packet. Output channel (out_valid / out_stall): exactly one result item
// per input item, in order. Config channel (cfg_valid / cfg_ready): writes
// my_ip (index 0) and my_mac (index 1); always ready, write only while idle.
//
// Sequence: the bucket's WAYS entries are read from a single-port-read memory,
// one way per cycle, then one write-back. With BUCKETS a power of two an item
// goes from accept straight to the way scan; other bucket counts first pass
// the hash and remainder states for the reciprocal-multiply remainder. The
// result is registered in the decide state. Broadcast resolves and ignored
// packets bypass the table and go from accept straight to the decide state.
//
// Reset: config registers clear; the table is then swept to zero, one entry
// per cycle, with in_stall high throughout.
// A stalled result holds in the output register; the next item may be accepted
// meanwhile and waits before write-back until that result has been taken.
module arp_cache_table_unit #(
    parameter int BUCKETS = arpct_pkg::DEF_BUCKETS,
    parameter int WAYS    = arpct_pkg::DEF_WAYS
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              opcode,
    input  logic [arpct_pkg::IP_W-1:0]        ip_addr,
    input  logic [arpct_pkg::IP_W-1:0]        target_ip,
    input  logic [arpct_pkg::MAC_W-1:0]       sender_mac,
    input  logic                              is_request,
    input  logic                              header_ok,
    input  logic [arpct_pkg::TIME_W-1:0]      now,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              resolved,
    output logic [arpct_pkg::MAC_W-1:0]       out_mac,
    output logic                              send_request,
    output logic                              send_held,
    output logic                              drop_held,
    output logic                              send_reply,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [arpct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [arpct_pkg::MAC_W-1:0]       cfg_data
);

    localparam int SLOTS  = BUCKETS * WAYS;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [arpct_pkg::IP_W-1:0]  my_ip_reg;
    logic [arpct_pkg::MAC_W-1:0] my_mac_reg;

    arpct_pkg::item_t   in_item;
    arpct_pkg::result_t res;

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    arpct_pkg::entry_t  rd_data;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    arpct_pkg::entry_t  wr_data;

    // Config registers; the port never back-pressures
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_ip_reg  <= '0;
            my_mac_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                arpct_pkg::CFG_MY_IP:  my_ip_reg  <= cfg_data[arpct_pkg::IP_W-1:0];
                arpct_pkg::CFG_MY_MAC: my_mac_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        in_item.opcode     = opcode;
        in_item.ip_addr    = ip_addr;
        in_item.target_ip  = target_ip;
        in_item.sender_mac = sender_mac;
        in_item.is_request = is_request;
        in_item.header_ok  = header_ok;
        in_item.now        = now;
    end

    arpct_ctrl #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS),
        .SLOTS   (SLOTS),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (res),
        .my_ip     (my_ip_reg),
        .my_mac    (my_mac_reg),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    arpct_mem #(
        .DEPTH  (SLOTS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign resolved     = res.resolved;
    assign out_mac      = res.out_mac;
    assign send_request = res.send_request;
    assign send_held    = res.send_held;
    assign drop_held    = res.drop_held;
    assign send_reply   = res.send_reply;

    // One item in flight: accept closes the input until the item is done
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item accepted right after the first");

    // A resolved address never comes with a new who-has
    a_resolved_no_request: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(resolved && send_request))
        else $error("resolved result also asks for the address");

    // Resolve results carry no received-packet actions
    a_resolved_no_rx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && resolved) |-> (!send_reply && !send_held))
        else $error("resolved result mixed with received-packet actions");

    // A released held packet never comes with a new who-has
    a_held_has_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && send_held) |-> !send_request)
        else $error("held packet released while still asking");

endmodule
